/* hw/rtl/smtp_pkg.sv */
package smtp_pkg;

   // session states
   localparam logic [2:0] SESS_CONNECT    = 3'd0;
   localparam logic [2:0] SESS_HELLO      = 3'd1;
   localparam logic [2:0] SESS_SENDER     = 3'd2;
   localparam logic [2:0] SESS_RECIPIENT  = 3'd3;
   localparam logic [2:0] SESS_LETTER     = 3'd4;
   localparam logic [2:0] SESS_DISCONNECT = 3'd5;

   // command-line phases
   localparam logic [1:0] PHASE_SKIP  = 2'd0;
   localparam logic [1:0] PHASE_TOKEN = 2'd1;
   localparam logic [1:0] PHASE_REST  = 2'd2;

   // body line status
   localparam logic [1:0] BODY_EMPTY = 2'd0;
   localparam logic [1:0] BODY_DOT   = 2'd1;
   localparam logic [1:0] BODY_OTHER = 2'd2;

   // verb indexes
   localparam int VERB_COUNT = 11;
   localparam logic [3:0] VERB_HELO = 4'd0;
   localparam logic [3:0] VERB_EHLO = 4'd1;
   localparam logic [3:0] VERB_MAIL = 4'd2;
   localparam logic [3:0] VERB_RCPT = 4'd3;
   localparam logic [3:0] VERB_DATA = 4'd4;
   localparam logic [3:0] VERB_RSET = 4'd5;
   localparam logic [3:0] VERB_VRFY = 4'd6;
   localparam logic [3:0] VERB_EXPN = 4'd7;
   localparam logic [3:0] VERB_HELP = 4'd8;
   localparam logic [3:0] VERB_NOOP = 4'd9;
   localparam logic [3:0] VERB_QUIT = 4'd10;
   localparam logic [3:0] VERB_NONE = 4'd11;

   localparam logic [31:0] VERB_WORDS [VERB_COUNT] = '{
      "helo", "ehlo", "mail", "rcpt", "data", "rset",
      "vrfy", "expn", "help", "noop", "quit"
   };

   localparam logic [2:0] TOKEN_VERB_LEN = 3'd4;
   localparam logic [2:0] TOKEN_LEN_MAX  = 3'd5;

   // reply kinds
   localparam logic [4:0] KIND_HELO_OK       = 5'd0;
   localparam logic [4:0] KIND_EHLO_OK       = 5'd1;
   localparam logic [4:0] KIND_DUP_HELO      = 5'd2;
   localparam logic [4:0] KIND_HELO_FIRST    = 5'd3;
   localparam logic [4:0] KIND_SENDER_OK     = 5'd4;
   localparam logic [4:0] KIND_SENDER_AGAIN  = 5'd5;
   localparam logic [4:0] KIND_RCPT_NO_MAIL  = 5'd6;
   localparam logic [4:0] KIND_RCPT_OK       = 5'd7;
   localparam logic [4:0] KIND_NEED_MAIL     = 5'd8;
   localparam logic [4:0] KIND_NEED_RCPT     = 5'd9;
   localparam logic [4:0] KIND_ENTER_MAIL    = 5'd10;
   localparam logic [4:0] KIND_RESET         = 5'd11;
   localparam logic [4:0] KIND_NOT_IMPL      = 5'd12;
   localparam logic [4:0] KIND_HELP          = 5'd13;
   localparam logic [4:0] KIND_OK            = 5'd14;
   localparam logic [4:0] KIND_CLOSING       = 5'd15;
   localparam logic [4:0] KIND_UNRECOGNIZED  = 5'd16;
   localparam logic [4:0] KIND_MSG_COMPLETE  = 5'd17;

   // reply numbers
   localparam logic [9:0] NUM_NONE    = 10'd0;
   localparam logic [9:0] NUM_HELP    = 10'd214;
   localparam logic [9:0] NUM_CLOSING = 10'd221;
   localparam logic [9:0] NUM_OK      = 10'd250;
   localparam logic [9:0] NUM_START   = 10'd354;
   localparam logic [9:0] NUM_SYNTAX  = 10'd500;
   localparam logic [9:0] NUM_NOTIMPL = 10'd502;
   localparam logic [9:0] NUM_BADSEQ  = 10'd503;

   localparam logic [7:0] CHAR_NEWLINE = 8'h0A;
   localparam logic [7:0] CHAR_DOT     = 8'h2E;

   typedef struct packed {
      logic [4:0] kind;
      logic [9:0] number;
      logic [2:0] session;
   } reply_type;

endpackage

/* hw/rtl/smtp_verb_decode.sv */
module smtp_verb_decode (
   input  logic [31:0] token_chars,
   input  logic [2:0]  token_length,
   output logic [3:0]  verb
);
   import smtp_pkg::*;

   always_comb begin
      verb = VERB_NONE;
      if (token_length == TOKEN_VERB_LEN) begin
         // table holds distinct words, so at most one hit
         for (int i = 0; i < VERB_COUNT; i++) begin
            if (token_chars == VERB_WORDS[i]) begin
               verb = 4'(i);
            end
         end
      end
   end

endmodule

/* hw/rtl/smtp_command_session_fsm.sv */
// Server side of an SMTP command session, one received byte per transfer on
// req_. Command lines are parsed on the fly: leading whitespace is skipped,
// the first token is lowercased and matched against HELO, EHLO, MAIL, RCPT,
// DATA, RSET, VRFY, EXPN, HELP, NOOP and QUIT, and the rest of the line is
// dropped. The newline that ends a command line produces one rsp_ transfer
// with the reply kind, the SMTP reply number and the session state after
// the command. Whitespace-only lines produce nothing. After DATA is
// accepted, body lines are swallowed until a line that is exactly "."
// (no carriage return), which yields a message-complete reply (number 0)
// and returns the session to hello. After QUIT every byte is dropped.
// Throughput is one byte per clock while the block does not hold off req_;
// a byte that produces a reply reaches rsp_ through the input register and
// then the result register. The session update is a combinational step
// between those two registers. The block only holds off req_ when the
// result register is still full and the byte in the input register wants
// to produce another reply.
module smtp_command_session_fsm (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [7:0] req_rx_byte,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [4:0] rsp_reply_kind,
   output logic [9:0] rsp_reply_number,
   output logic [2:0] rsp_session_state
);
   import smtp_pkg::*;

   // input register
   logic       byte_valid_ff, byte_valid_in;
   logic [7:0] byte_ff;

   // session state
   logic [2:0]  session_ff, session_in;
   logic [1:0]  phase_ff, phase_in;
   logic [31:0] token_ff, token_in;
   logic [2:0]  tlen_ff, tlen_in;
   logic [1:0]  body_ff, body_in;

   // result register
   logic      rsp_valid_ff, rsp_valid_in;
   reply_type reply_ff;

   logic       is_space, is_nl;
   logic [7:0] lower_byte;
   logic [3:0] verb;
   logic       emit;
   logic       stall, step;
   reply_type  reply_in;
   reply_type  verb_reply;

   smtp_verb_decode u_verb (
      .token_chars  (token_ff),
      .token_length (tlen_ff),
      .verb         (verb)
   );

   assign is_nl      = (byte_ff == CHAR_NEWLINE);
   assign is_space   = (byte_ff == 8'h20) || (byte_ff >= 8'h09 && byte_ff <= 8'h0D);
   assign lower_byte = (byte_ff >= 8'h41 && byte_ff <= 8'h5A) ? (byte_ff + 8'h20) : byte_ff;

   // reply and next session for the collected verb
   always_comb begin
      verb_reply.kind    = KIND_UNRECOGNIZED;
      verb_reply.number  = NUM_SYNTAX;
      verb_reply.session = session_ff;
      case (verb)
         VERB_HELO, VERB_EHLO: begin
            if (session_ff == SESS_CONNECT) begin
               verb_reply.kind    = (verb == VERB_HELO) ? KIND_HELO_OK : KIND_EHLO_OK;
               verb_reply.number  = NUM_OK;
               verb_reply.session = SESS_HELLO;
            end else begin
               verb_reply.kind   = KIND_DUP_HELO;
               verb_reply.number = NUM_BADSEQ;
            end
         end
         VERB_MAIL: begin
            if (session_ff == SESS_CONNECT) begin
               verb_reply.kind   = KIND_HELO_FIRST;
               verb_reply.number = NUM_BADSEQ;
            end else if (session_ff == SESS_HELLO) begin
               verb_reply.kind    = KIND_SENDER_OK;
               verb_reply.number  = NUM_OK;
               verb_reply.session = SESS_SENDER;
            end else begin
               verb_reply.kind   = KIND_SENDER_AGAIN;
               verb_reply.number = NUM_BADSEQ;
            end
         end
         VERB_RCPT: begin
            if (session_ff == SESS_SENDER || session_ff == SESS_RECIPIENT) begin
               verb_reply.kind    = KIND_RCPT_OK;
               verb_reply.number  = NUM_OK;
               verb_reply.session = SESS_RECIPIENT;
            end else begin
               verb_reply.kind   = KIND_RCPT_NO_MAIL;
               verb_reply.number = NUM_BADSEQ;
            end
         end
         VERB_DATA: begin
            if (session_ff == SESS_RECIPIENT) begin
               verb_reply.kind    = KIND_ENTER_MAIL;
               verb_reply.number  = NUM_START;
               verb_reply.session = SESS_LETTER;
            end else if (session_ff == SESS_SENDER) begin
               verb_reply.kind   = KIND_NEED_RCPT;
               verb_reply.number = NUM_BADSEQ;
            end else begin
               verb_reply.kind   = KIND_NEED_MAIL;
               verb_reply.number = NUM_BADSEQ;
            end
         end
         VERB_RSET: begin
            verb_reply.kind   = KIND_RESET;
            verb_reply.number = NUM_OK;
            if (session_ff != SESS_CONNECT) begin
               verb_reply.session = SESS_HELLO;
            end
         end
         VERB_VRFY, VERB_EXPN: begin
            verb_reply.kind   = KIND_NOT_IMPL;
            verb_reply.number = NUM_NOTIMPL;
         end
         VERB_HELP: begin
            verb_reply.kind   = KIND_HELP;
            verb_reply.number = NUM_HELP;
         end
         VERB_NOOP: begin
            verb_reply.kind   = KIND_OK;
            verb_reply.number = NUM_OK;
         end
         VERB_QUIT: begin
            verb_reply.kind    = KIND_CLOSING;
            verb_reply.number  = NUM_CLOSING;
            verb_reply.session = SESS_DISCONNECT;
         end
         default: begin
            verb_reply.kind   = KIND_UNRECOGNIZED;
            verb_reply.number = NUM_SYNTAX;
         end
      endcase
   end

   // per-byte session step
   always_comb begin
      session_in = session_ff;
      phase_in   = phase_ff;
      token_in   = token_ff;
      tlen_in    = tlen_ff;
      body_in    = body_ff;
      emit       = 1'b0;
      reply_in   = verb_reply;

      if (session_ff == SESS_LETTER) begin
         if (is_nl) begin
            if (body_ff == BODY_DOT) begin
               emit               = 1'b1;
               reply_in.kind      = KIND_MSG_COMPLETE;
               reply_in.number    = NUM_NONE;
               reply_in.session   = SESS_HELLO;
            end
            body_in = BODY_EMPTY;
         end else begin
            body_in = (body_ff == BODY_EMPTY && byte_ff == CHAR_DOT) ? BODY_DOT : BODY_OTHER;
         end
      end else if (session_ff < SESS_LETTER) begin
         case (phase_ff)
            PHASE_SKIP: begin
               if (!is_space) begin
                  token_in = {24'd0, lower_byte};
                  tlen_in  = 3'd1;
                  phase_in = PHASE_TOKEN;
               end
            end
            PHASE_TOKEN: begin
               if (is_space) begin
                  if (is_nl) begin
                     emit = 1'b1;
                  end else begin
                     phase_in = PHASE_REST;
                  end
               end else begin
                  token_in = {token_ff[23:0], lower_byte};
                  if (tlen_ff < TOKEN_LEN_MAX) begin
                     tlen_in = tlen_ff + 3'd1;
                  end
               end
            end
            default: begin
               if (is_nl) begin
                  emit = 1'b1;
               end
            end
         endcase
      end
      // disconnect: nothing changes

      if (emit) begin
         session_in = reply_in.session;
         phase_in   = PHASE_SKIP;
         token_in   = '0;
         tlen_in    = '0;
         body_in    = BODY_EMPTY;
      end
   end

   // hold the byte only if it needs the result register and that is still full
   assign stall     = byte_valid_ff && emit && rsp_valid_ff && !rsp_ready;
   assign step      = byte_valid_ff && !stall;
   assign req_ready = !stall;

   always_comb begin
      byte_valid_in = byte_valid_ff;
      if (req_valid && req_ready) begin
         byte_valid_in = 1'b1;
      end else if (step) begin
         byte_valid_in = 1'b0;
      end
      rsp_valid_in = rsp_valid_ff;
      if (step && emit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         byte_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         session_ff    <= SESS_CONNECT;
         phase_ff      <= PHASE_SKIP;
         token_ff      <= '0;
         tlen_ff       <= '0;
         body_ff       <= BODY_EMPTY;
      end else begin
         byte_valid_ff <= byte_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
         if (step) begin
            session_ff <= session_in;
            phase_ff   <= phase_in;
            token_ff   <= token_in;
            tlen_ff    <= tlen_in;
            body_ff    <= body_in;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         byte_ff <= req_rx_byte;
      end
      if (step && emit) begin
         reply_ff <= reply_in;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_reply_kind    = reply_ff.kind;
   assign rsp_reply_number  = reply_ff.number;
   assign rsp_session_state = reply_ff.session;

endmodule

/* hw/rtl/smtp_checker.sv */
module smtp_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_valid,
   input logic       req_ready,
   input logic [7:0] req_rx_byte,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [4:0] rsp_reply_kind,
   input logic [9:0] rsp_reply_number,
   input logic [2:0] rsp_session_state
);
   import smtp_pkg::*;

   // a waiting byte holds
   a_req_hold: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_ready |=> req_valid && $stable(req_rx_byte))
      else $error("byte changed while waiting");

   // a stalled reply holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_reply_kind)
         && $stable(rsp_reply_number) && $stable(rsp_session_state))
      else $error("reply changed while stalled");

   // end of message returns to hello with no number
   a_msg_done: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_reply_kind == KIND_MSG_COMPLETE |->
         rsp_reply_number == NUM_NONE && rsp_session_state == SESS_HELLO)
      else $error("bad message-complete reply");

   // quit closes the session
   a_quit: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_reply_kind == KIND_CLOSING |->
         rsp_reply_number == NUM_CLOSING && rsp_session_state == SESS_DISCONNECT)
      else $error("bad closing reply");

   // only the DATA acceptance reply leaves the session in letter
   a_letter: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_session_state == SESS_LETTER |->
         rsp_reply_kind == KIND_ENTER_MAIL && rsp_reply_number == NUM_START)
      else $error("letter state with wrong reply");

endmodule

bind smtp_command_session_fsm smtp_checker u_smtp_checker (
   .clock             (clock),
   .reset             (reset),
   .req_valid         (req_valid),
   .req_ready         (req_ready),
   .req_rx_byte       (req_rx_byte),
   .rsp_valid         (rsp_valid),
   .rsp_ready         (rsp_ready),
   .rsp_reply_kind    (rsp_reply_kind),
   .rsp_reply_number  (rsp_reply_number),
   .rsp_session_state (rsp_session_state)
);
